// ===== hdl/psbs_pkg.sv =====
package psbs_pkg;

    localparam int ALPHABET   = 64;
    localparam int BOUND_BITS = 16;
    localparam int IDX_W      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int SYM_W      = 6;
    localparam int CNT_W      = 16;
    localparam int SUM_W      = 32;
    localparam int MAX_W      = 16;

    typedef enum logic [1:0] {
        FN_ACC = 2'd0,
        FN_RD  = 2'd1,
        FN_CLR = 2'd2
    } t_func;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] hit;
    } t_stat;

    typedef struct packed {
        logic             wr;
        logic             clr;
        logic             rise;
        logic [IDX_W-1:0] idx;
        t_stat            stat;
    } t_upd;

endpackage

// ===== hdl/psbs_update.sv =====
module psbs_update
    import psbs_pkg::*;
(
    input  logic                  i_vld,
    input  t_func                 i_func,
    input  logic [SYM_W-1:0]      i_sym,
    input  logic                  i_active,
    input  logic [15:0]           i_bound,
    input  t_stat                 i_stat,
    input  logic [BOUND_BITS-1:0] i_max,
    output t_upd                  o_upd,
    output t_stat                 o_rd_stat,
    output logic [BOUND_BITS-1:0] o_max_nxt
);

    logic                  sym_ok;
    logic [BOUND_BITS-1:0] b;
    logic                  rise;
    logic [BOUND_BITS-1:0] max_new;
    logic                  acc;
    logic [SUM_W:0]        sum_ext;
    logic [CNT_W-1:0]      hit_base;

    assign sym_ok   = (int'(i_sym) < ALPHABET);
    assign b        = BOUND_BITS'(i_bound);
    assign rise     = (b > i_max);
    assign max_new  = rise ? b : i_max;
    assign acc      = i_vld && (i_func == FN_ACC) && i_active;
    assign sum_ext  = {1'b0, i_stat.sum} + (SUM_W + 1)'(b);
    assign hit_base = rise ? '0 : i_stat.hit;

    always_comb begin
        o_upd.wr       = acc && sym_ok;
        o_upd.clr      = i_vld && (i_func == FN_CLR);
        o_upd.rise     = acc && rise;
        o_upd.idx      = IDX_W'(i_sym);
        o_upd.stat.cnt = (&i_stat.cnt) ? i_stat.cnt : i_stat.cnt + 1'b1;
        o_upd.stat.sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (b == max_new && !(&hit_base)) begin
            o_upd.stat.hit = hit_base + 1'b1;
        end else begin
            o_upd.stat.hit = hit_base;
        end
    end

    assign o_rd_stat = sym_ok ? i_stat : '0;

    always_comb begin
        if (o_upd.clr) begin
            o_max_nxt = '0;
        end else if (acc) begin
            o_max_nxt = max_new;
        end else begin
            o_max_nxt = i_max;
        end
    end

endmodule

// ===== hdl/psbs_store.sv =====
module psbs_store
    import psbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ld,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  t_upd             i_upd,
    output t_stat            o_stat
);

    logic [CNT_W-1:0]    mem_cnt [ALPHABET];
    logic [SUM_W-1:0]    mem_sum [ALPHABET];
    logic [CNT_W-1:0]    mem_hit [ALPHABET];
    logic [ALPHABET-1:0] r_cv;
    logic [ALPHABET-1:0] r_hv;
    logic [ALPHABET-1:0] n_cv;
    logic [ALPHABET-1:0] n_hv;
    t_stat               r_stat;

    // entry valid bits: clear-all clears them all, a new maximum clears the hit valid bits
    always_comb begin
        n_cv = r_cv;
        n_hv = r_hv;
        if (i_upd.clr) begin
            n_cv = '0;
            n_hv = '0;
        end else begin
            if (i_upd.rise) begin
                n_hv = '0;
            end
            if (i_upd.wr) begin
                n_cv[i_upd.idx] = 1'b1;
                n_hv[i_upd.idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
            r_hv <= '0;
        end else begin
            r_cv <= n_cv;
            r_hv <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.wr) begin
            mem_cnt[i_upd.idx] <= i_upd.stat.cnt;
            mem_sum[i_upd.idx] <= i_upd.stat.sum;
            mem_hit[i_upd.idx] <= i_upd.stat.hit;
        end
    end

    // registered read with bypass of the write in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            if (i_upd.wr && i_upd.idx == i_rd_idx) begin
                r_stat <= i_upd.stat;
            end else if (i_upd.clr) begin
                r_stat <= '0;
            end else begin
                r_stat.cnt <= r_cv[i_rd_idx] ? mem_cnt[i_rd_idx] : '0;
                r_stat.sum <= r_cv[i_rd_idx] ? mem_sum[i_rd_idx] : '0;
                r_stat.hit <= (r_hv[i_rd_idx] && !i_upd.rise) ? mem_hit[i_rd_idx] : '0;
            end
        end
    end

    assign o_stat = r_stat;

endmodule

// ===== hdl/per_symbol_bound_statistics.sv =====
// an accepted read transfer is held in the input stage registers, then its result in the output register on o_m_tdata
// throughput: one transfer per cycle while the output is not held by i_m_tready low, reads and updates back to back
// the per-symbol stores are flop arrays with one read-modify-write per cycle
// reset (synchronous, active low) clears all statistics and the running maximum at once
module per_symbol_bound_statistics
    import psbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // symbol[5:0], active[6], bound[22:7], zero fill
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // match_count, bound_sum, max_hits, running_max
);

    logic                  r_s1_vld;
    t_func                 r_s1_func;
    logic [SYM_W-1:0]      r_s1_sym;
    logic                  r_s1_active;
    logic [15:0]           r_s1_bound;
    logic [BOUND_BITS-1:0] r_max;
    logic                  r_out_vld;
    t_stat                 r_out_stat;
    logic [MAX_W-1:0]      r_out_max;

    logic                  s1_adv;
    logic                  accept;
    t_stat                 s1_stat;
    t_stat                 rd_stat;
    t_upd                  upd;
    logic [BOUND_BITS-1:0] n_max;

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    psbs_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (accept),
        .i_rd_idx (IDX_W'(i_s_tdata[5:0])),
        .i_upd    (upd),
        .o_stat   (s1_stat)
    );

    psbs_update u_update (
        .i_vld     (s1_adv),
        .i_func    (r_s1_func),
        .i_sym     (r_s1_sym),
        .i_active  (r_s1_active),
        .i_bound   (r_s1_bound),
        .i_stat    (s1_stat),
        .i_max     (r_max),
        .o_upd     (upd),
        .o_rd_stat (rd_stat),
        .o_max_nxt (n_max)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_max     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            r_max <= n_max;
            if (s1_adv && r_s1_func == FN_RD) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func   <= t_func'(i_s_tuser);
            r_s1_sym    <= i_s_tdata[5:0];
            r_s1_active <= i_s_tdata[6];
            r_s1_bound  <= i_s_tdata[22:7];
        end
        if (s1_adv && r_s1_func == FN_RD) begin
            r_out_stat <= rd_stat;
            r_out_max  <= MAX_W'(r_max);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_max, r_out_stat.hit, r_out_stat.sum, r_out_stat.cnt};

`ifndef SYNTH
    a_max_falls_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_max < $past(r_max))
            |-> $past(s1_adv && r_s1_func == FN_CLR))
        else $error("running maximum fell without a clear");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_vld)) |-> $past(r_s1_vld && r_s1_func == FN_RD))
        else $error("result raised without a read");

    a_hits_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_stat.hit <= r_out_stat.cnt))
        else $error("max hits exceed match count");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top
    import psbs_pkg::*;
();

    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]       func;
        logic [SYM_W-1:0] sym;
        logic             act;
        logic [MAX_W-1:0] bound;
    } t_match_item;

    // same layout as o_m_tdata, match_count in the lowest bits
    typedef struct packed {
        logic [MAX_W-1:0] running_max;
        logic [CNT_W-1:0] max_hits;
        logic [SUM_W-1:0] bound_sum;
        logic [CNT_W-1:0] match_count;
    } t_readout;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    per_symbol_bound_statistics i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted statistics
    logic [CNT_W-1:0] tally_cnt [ALPHABET];
    logic [SUM_W-1:0] tally_sum [ALPHABET];
    logic [CNT_W-1:0] tally_hit [ALPHABET];
    logic [MAX_W-1:0] peak_bound;

    t_match_item match_q[$];
    t_readout    readout_q[$];
    t_match_item cur_item;

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_pauses = 0;
    int err_cnt = 0;
    int gap_left = 0;
    int stall_left = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    bit quiet = 1'b0;

    function void clear_tallies();
        for (int k = 0; k < ALPHABET; k++) begin
            tally_cnt[k] = '0;
            tally_sum[k] = '0;
            tally_hit[k] = '0;
        end
        peak_bound = '0;
    endfunction

    function void update_tallies(input t_match_item it);
        logic [SUM_W:0] wide;
        t_readout       rd;
        case (it.func)
            FN_ACC: begin
                if (it.act) begin
                    if (it.bound > peak_bound) begin
                        peak_bound = it.bound;
                        for (int k = 0; k < ALPHABET; k++)
                            tally_hit[k] = '0;
                    end
                    if (tally_cnt[it.sym] != '1)
                        tally_cnt[it.sym] = tally_cnt[it.sym] + 1'b1;
                    wide = {1'b0, tally_sum[it.sym]} + (SUM_W + 1)'(it.bound);
                    tally_sum[it.sym] = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
                    if (it.bound == peak_bound && tally_hit[it.sym] != '1)
                        tally_hit[it.sym] = tally_hit[it.sym] + 1'b1;
                end
            end
            FN_RD: begin
                rd.match_count = tally_cnt[it.sym];
                rd.bound_sum   = tally_sum[it.sym];
                rd.max_hits    = tally_hit[it.sym];
                rd.running_max = peak_bound;
                readout_q = {readout_q, rd};
            end
            FN_CLR: clear_tallies();
            default: ;
        endcase
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        if (err_cnt < 100)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // sender side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                update_tallies(cur_item);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (!quiet && match_q.size() != 0 && $urandom_range(99) < gap_pct) begin
                    gap_left = $urandom_range(4, 0);
                    s_tvalid <= 1'b0;
                end else if (match_q.size() != 0) begin
                    cur_item = match_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_item.bound, cur_item.act, cur_item.sym};
                    s_tuser  <= cur_item.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(4, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_readout got;
        t_readout want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (readout_q.size() == 0) begin
                report_mismatch("result transfer with none expected", got.bound_sum, '0);
            end else begin
                want = readout_q.pop_front();
                n_checked++;
                if (got.match_count !== want.match_count)
                    report_mismatch("match_count", 32'(got.match_count),
                                    32'(want.match_count));
                if (got.bound_sum !== want.bound_sum)
                    report_mismatch("bound_sum", got.bound_sum, want.bound_sum);
                if (got.max_hits !== want.max_hits)
                    report_mismatch("max_hits", 32'(got.max_hits), 32'(want.max_hits));
                if (got.running_max !== want.running_max)
                    report_mismatch("running_max", 32'(got.running_max),
                                    32'(want.running_max));
            end
        end
    end

    function void push_item(input logic [1:0] fn, input logic [SYM_W-1:0] sym,
                            input logic act, input logic [MAX_W-1:0] bound);
        t_match_item it;
        it.func  = fn;
        it.sym   = sym;
        it.act   = act;
        it.bound = bound;
        match_q = {match_q, it};
        n_queued++;
    endfunction

    function void push_random(input int sym_hi, input int bound_hi);
        int         pick;
        logic [1:0] fn;
        pick = $urandom_range(99);
        if (pick < 66)
            fn = FN_ACC;
        else if (pick < 94)
            fn = FN_RD;
        else if (pick < 97)
            fn = FN_CLR;
        else
            fn = FN_UNUSED;
        push_item(fn, SYM_W'($urandom_range(sym_hi)), $urandom_range(9) != 0,
                  MAX_W'($urandom_range(bound_hi)));
    endfunction

    task wait_drained();
        while (!(n_accepted == n_queued && readout_q.size() == 0))
            @(posedge i_clk);
        n_pauses++;
    endtask

    initial begin
        int sym_hi [5];
        int bound_hi [5];
        int gaps [5];
        int stalls [5];
        sym_hi   = '{3, 63, 15, 7, 63};
        bound_hi = '{7, 65535, 255, 3, 31};
        gaps     = '{30, 20, 0, 50, 0};
        stalls   = '{30, 0, 40, 50, 0};
        clear_tallies();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct   = 25;
        stall_pct = 25;

        push_item(FN_RD, 0, 1'b0, '0);
        push_item(FN_ACC, 0, 1'b1, '0);
        push_item(FN_RD, 0, 1'b0, '0);
        push_item(FN_ACC, 63, 1'b0, 16'hFFFF);
        push_item(FN_RD, 63, 1'b0, '0);
        push_item(FN_ACC, 63, 1'b1, 16'hFFFF);
        push_item(FN_RD, 63, 1'b0, '0);
        push_item(FN_RD, 0, 1'b0, '0);
        push_item(FN_ACC, 0, 1'b1, 16'h1234);
        push_item(FN_ACC, 0, 1'b1, 16'hFFFF);
        push_item(FN_RD, 0, 1'b0, '0);
        push_item(FN_UNUSED, 42, 1'b1, 16'hFFFF);
        push_item(FN_RD, 42, 1'b0, '0);
        push_item(FN_CLR, 63, 1'b1, 16'hFFFF);
        push_item(FN_RD, 63, 1'b0, '0);
        push_item(FN_ACC, 42, 1'b1, 16'h5555);
        push_item(FN_ACC, 21, 1'b1, 16'hAAAA);
        push_item(FN_RD, 42, 1'b0, '0);
        push_item(FN_RD, 21, 1'b0, '0);
        push_item(FN_RD, 6'h2A, 1'b1, 16'hAAAA);
        wait_drained();

        // a run of hits at the top bound on one symbol
        gap_pct   = 10;
        stall_pct = 10;
        push_item(FN_ACC, 5, 1'b1, 16'h0001);
        for (int k = 0; k < 40; k++)
            push_item(FN_ACC, 5, 1'b1, 16'hFFFF);
        push_item(FN_RD, 5, 1'b0, '0);
        push_item(FN_ACC, 5, 1'b1, 16'hFFFF);
        push_item(FN_RD, 5, 1'b0, '0);
        push_item(FN_RD, 6, 1'b0, '0);
        push_item(FN_CLR, 0, 1'b0, '0);
        push_item(FN_RD, 5, 1'b0, '0);
        wait_drained();

        for (int c = 0; c < 5; c++) begin
            gap_pct   = gaps[c];
            stall_pct = stalls[c];
            quiet     = (c == 4);
            for (int k = 0; k < 240; k++)
                push_random(sym_hi[c], bound_hi[c]);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("stimulus: %0d transfers accepted, %0d readouts checked", n_accepted, n_checked);
        $display("covered max rises, hit runs, clears and %0d drain pauses", n_pauses);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timeout");
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== per_symbol_bound_statistics.f =====
hdl/psbs_pkg.sv
hdl/psbs_update.sv
hdl/psbs_store.sv
hdl/per_symbol_bound_statistics.sv
tb/sv/tb_top.sv
